>>> rtl/halfband_allpass_resampler_2x_macros.svh
// Assertion macros for the halfband allpass resampler.
// Included by the top level; no other dependencies.
`ifndef HALFBAND_ALLPASS_RESAMPLER_2X_MACROS_SVH
`define HALFBAND_ALLPASS_RESAMPLER_2X_MACROS_SVH

// Same-cycle implication, disabled during reset
`define HBAR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define HBAR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/hbar_pkg.sv
// Shared types, widths, coefficient table and saturation helpers for the
// halfband allpass resampler. No dependencies.
`default_nettype none

package hbar_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int GUARD_BITS   = 4;
  localparam int STATE_WIDTH  = SAMPLE_WIDTH + GUARD_BITS;
  localparam int COEF_WIDTH   = 18;
  localparam int COEF_FRAC    = 18;
  localparam int DIFF_WIDTH   = STATE_WIDTH + 1;
  localparam int PROD_WIDTH   = DIFF_WIDTH + COEF_WIDTH + 1;
  localparam int RND_WIDTH    = PROD_WIDTH - COEF_FRAC;
  localparam int SUM_WIDTH    = RND_WIDTH + 1;
  localparam int NUM_SECT     = 3;
  localparam int SECT_W       = 2;
  localparam int STEP_W       = 3;
  localparam int NUM_STEPS    = 2 * NUM_SECT;
  localparam int TDATA_IN_W   = 2 * SAMPLE_WIDTH;
  localparam int TDATA_OUT_W  = SAMPLE_WIDTH;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

  typedef enum logic {
    PATH_LOWER = 1'b0,
    PATH_UPPER = 1'b1
  } path_e;

  typedef enum logic {
    MODE_UP   = 1'b0,
    MODE_DOWN = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT_A,
    ST_EMIT_B
  } fsm_e;

  // Control word that travels with one section operation through the unit
  typedef struct packed {
    logic              valid;
    path_e             path;
    logic [SECT_W-1:0] sect;
  } sec_ctl_t;

  // Q0.18 allpass coefficients, three per path
  function automatic logic [COEF_WIDTH-1:0] coef_lookup(path_e p, logic [SECT_W-1:0] k);
    logic [COEF_WIDTH-1:0] c;
    c = '0;
    unique case ({p, k})
      {PATH_LOWER, 2'd0}: c = COEF_WIDTH'(10263);
      {PATH_LOWER, 2'd1}: c = COEF_WIDTH'(79337);
      {PATH_LOWER, 2'd2}: c = COEF_WIDTH'(176847);
      {PATH_UPPER, 2'd0}: c = COEF_WIDTH'(38634);
      {PATH_UPPER, 2'd1}: c = COEF_WIDTH'(126476);
      {PATH_UPPER, 2'd2}: c = COEF_WIDTH'(231474);
      default:            c = '0;
    endcase
    return c;
  endfunction

  // Clamp a section sum to the state word range
  function automatic logic signed [STATE_WIDTH-1:0] sat_state(
    logic signed [SUM_WIDTH-1:0] v
  );
    logic signed [SUM_WIDTH-1:0] hi;
    logic signed [SUM_WIDTH-1:0] lo;
    hi = SUM_WIDTH'((64'sd1 <<< (STATE_WIDTH - 1)) - 64'sd1);
    lo = -hi - SUM_WIDTH'(1);
    if (v > hi) return hi[STATE_WIDTH-1:0];
    if (v < lo) return lo[STATE_WIDTH-1:0];
    return v[STATE_WIDTH-1:0];
  endfunction

  // Clamp a state word to the sample range
  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
    logic signed [STATE_WIDTH-1:0] v
  );
    logic signed [STATE_WIDTH-1:0] hi;
    logic signed [STATE_WIDTH-1:0] lo;
    hi = STATE_WIDTH'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    lo = -hi - STATE_WIDTH'(1);
    if (v > hi) return hi[SAMPLE_WIDTH-1:0];
    if (v < lo) return lo[SAMPLE_WIDTH-1:0];
    return v[SAMPLE_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/hbar_alu.sv
// Shared two-stage allpass section unit: multiply, then round, add, saturate.
// Depends on hbar_pkg.
`default_nettype none

module hbar_alu
  import hbar_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire sec_ctl_t                      issue_i,
  input  wire logic signed [STATE_WIDTH-1:0] x_i,
  input  wire logic signed [STATE_WIDTH-1:0] y_prev_i,
  input  wire logic signed [STATE_WIDTH-1:0] x_prev_i,
  input  wire logic [COEF_WIDTH-1:0]         coef_i,
  output sec_ctl_t                           wb_o,
  output logic signed [STATE_WIDTH-1:0]      y_o,
  output logic signed [STATE_WIDTH-1:0]      x_o
);

  logic signed [DIFF_WIDTH-1:0]   diff;
  logic signed [COEF_WIDTH:0]     coef_s;
  logic signed [PROD_WIDTH-1:0]   prod_d, prod_q;
  logic signed [STATE_WIDTH-1:0]  x_q, x_prev_q;
  sec_ctl_t                       ctl_q;
  logic signed [PROD_WIDTH-1:0]   rnd_full;
  logic signed [RND_WIDTH-1:0]    rnd;
  logic signed [SUM_WIDTH-1:0]    sum;

  // Stage one: (x - y_prev) * a
  assign diff   = DIFF_WIDTH'(x_i) - DIFF_WIDTH'(y_prev_i);
  assign coef_s = $signed({1'b0, coef_i});
  assign prod_d = PROD_WIDTH'(diff) * PROD_WIDTH'(coef_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= issue_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    x_q      <= x_i;
    x_prev_q <= x_prev_i;
  end

  // Stage two: round half up to the sample LSB, add x_prev, clamp
  assign rnd_full = prod_q + (PROD_WIDTH'(1) <<< (COEF_FRAC - 1));
  assign rnd      = rnd_full[PROD_WIDTH-1:COEF_FRAC];
  assign sum      = SUM_WIDTH'(rnd) + SUM_WIDTH'(x_prev_q);

  assign y_o  = sat_state(sum);
  assign x_o  = x_q;
  assign wb_o = ctl_q;

endmodule

`default_nettype wire

>>> rtl/halfband_allpass_resampler_2x.sv
// Two-path polyphase IIR halfband resampler by two: sequencer, section state
// and output register. Depends on hbar_pkg, hbar_alu and the macros header.
//
// Usage:
//   Samples enter on the s_axis channel (first_sample in tdata[23:0],
//   second_sample in tdata[47:24]); results leave on m_axis (sample_out in
//   tdata, last_of_run on tlast). The user must write resample_mode on the cfg
//   channel (always ready) only while the block is idle; the block itself does
//   not enforce this. 0 upsamples one sample to two results (lower path, then
//   upper path), 1 downsamples a pair to the rounded mean of its two path
//   outputs. One item runs six allpass sections through a single two-stage
//   multiply/round/saturate unit, one section issued per cycle with the two
//   paths interleaved, so the pipeline never waits on its own result.
//   After the input transfer the sequencer issues the six steps in ST_RUN,
//   waits in ST_DRAIN for the last write-back, then loads the output register
//   in ST_EMIT_A, and in ST_EMIT_B too when upsampling. tready is low while an
//   item is in work. A one-entry output register holds a result while the
//   receiver stalls; the block accepts the next item while it waits, and
//   sequencing halts at the emit step until the register frees.
//   Reset clears all section state, the mode (upsample) and the output valid flag.
`default_nettype none

`include "halfband_allpass_resampler_2x_macros.svh"

module halfband_allpass_resampler_2x
  import hbar_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration write
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic                   cfg_data_i,     // resample_mode
  // input stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [TDATA_IN_W-1:0]  s_axis_tdata,   // [23:0] first_sample, [47:24] second_sample
  // output stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0]      m_axis_tdata,   // [23:0] sample_out
  output logic                        m_axis_tlast    // last_of_run
);

  fsm_e                           state_q, state_d;
  logic [STEP_W-1:0]              step_q;
  mode_e                          mode_q;
  logic signed [STATE_WIDTH-1:0]  sec_out_q  [2][NUM_SECT];
  logic signed [STATE_WIDTH-1:0]  in_prev_q  [2][NUM_SECT];
  logic signed [STATE_WIDTH-1:0]  carry_q    [2];
  logic                           out_valid_q;
  logic [SAMPLE_WIDTH-1:0]        out_data_q;
  logic                           out_last_q;

  logic                           accept;
  logic                           out_free;
  logic                           load;
  logic [SAMPLE_WIDTH-1:0]        load_data;
  logic                           load_last;
  sec_ctl_t                       issue;
  sec_ctl_t                       wb;
  logic signed [STATE_WIDTH-1:0]  alu_y, alu_x;
  logic signed [SAMPLE_WIDTH-1:0] first_s, second_s;
  logic signed [STATE_WIDTH:0]    pair_sum;
  logic signed [STATE_WIDTH-1:0]  mean;

  assign first_s  = s_axis_tdata[SAMPLE_WIDTH-1:0];
  assign second_s = s_axis_tdata[TDATA_IN_W-1:SAMPLE_WIDTH];

  assign cfg_ready_o = 1'b1;
  assign accept      = s_axis_tvalid && s_axis_tready;
  assign out_free    = !out_valid_q || m_axis_tready;

  // Current section: even steps lower path, odd steps upper path
  assign issue.valid = (state_q == ST_RUN);
  assign issue.path  = path_e'(step_q[0]);
  assign issue.sect  = step_q[STEP_W-1:1];

  hbar_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .issue_i  (issue),
    .x_i      (carry_q[issue.path]),
    .y_prev_i (sec_out_q[issue.path][issue.sect]),
    .x_prev_i (in_prev_q[issue.path][issue.sect]),
    .coef_i   (coef_lookup(issue.path, issue.sect)),
    .wb_o     (wb),
    .y_o      (alu_y),
    .x_o      (alu_x)
  );

  // Mean of the two path outputs, rounded half up
  assign pair_sum = (STATE_WIDTH+1)'(carry_q[PATH_LOWER]) +
                    (STATE_WIDTH+1)'(carry_q[PATH_UPPER]) + (STATE_WIDTH+1)'(1);
  assign mean     = pair_sum[STATE_WIDTH:1];

  // Next state, ready and output load
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    load          = 1'b0;
    load_data     = '0;
    load_last     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (step_q == LAST_STEP) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_EMIT_A;
      end
      ST_EMIT_A: begin
        if (mode_q == MODE_DOWN) begin
          load_data = sat_sample(mean);
          load_last = 1'b1;
        end else begin
          load_data = sat_sample(carry_q[PATH_LOWER]);
          load_last = 1'b0;
        end
        if (out_free) begin
          load    = 1'b1;
          state_d = (mode_q == MODE_DOWN) ? ST_IDLE : ST_EMIT_B;
        end
      end
      ST_EMIT_B: begin
        load_data = sat_sample(carry_q[PATH_UPPER]);
        load_last = 1'b1;
        if (out_free) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Step counter: clear on transfer, advance while issuing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (accept) begin
      step_q <= '0;
    end else if (state_q == ST_RUN) begin
      step_q <= step_q + STEP_W'(1);
    end
  end

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_UP;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= mode_e'(cfg_data_i);
    end
  end

  // Section state: write back each finished section
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < 2; p++) begin
        for (int k = 0; k < NUM_SECT; k++) begin
          sec_out_q[p][k] <= '0;
          in_prev_q[p][k] <= '0;
        end
      end
    end else if (wb.valid) begin
      sec_out_q[wb.path][wb.sect] <= alu_y;
      in_prev_q[wb.path][wb.sect] <= alu_x;
    end
  end

  // Path carry: load the path input on transfer, then each section output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q[PATH_LOWER] <= '0;
      carry_q[PATH_UPPER] <= '0;
    end else if (accept) begin
      carry_q[PATH_UPPER] <= STATE_WIDTH'(first_s);
      carry_q[PATH_LOWER] <= (mode_q == MODE_DOWN) ? STATE_WIDTH'(second_s)
                                                   : STATE_WIDTH'(first_s);
    end else if (wb.valid) begin
      carry_q[wb.path] <= alu_y;
    end
  end

  // Output register: hold until the receiver takes the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= load_data;
      out_last_q <= load_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // The section unit is empty whenever a new item may enter
  `HBAR_ASSERT_IMP(a_idle_alu_empty, clk_i, rst_ni, s_axis_tready, !wb.valid && !issue.valid, "section unit busy while ready")
  // An input transfer starts the sequence at the first step
  `HBAR_ASSERT_NXT(a_accept_starts, clk_i, rst_ni, accept, state_q == ST_RUN && step_q == '0, "transfer did not start run")
  // The second upsample result always closes the run
  `HBAR_ASSERT_NXT(a_emit_b_last, clk_i, rst_ni, state_q == ST_EMIT_B && load, m_axis_tvalid && m_axis_tlast, "second result not marked last")
  // Every issue is followed by the write-back of the same section in the cycle after
  `HBAR_ASSERT_NXT(a_wb_follows_issue, clk_i, rst_ni, issue.valid, wb.valid && wb.sect == $past(issue.sect), "write-back lost")

endmodule

`default_nettype wire

>>> tb/hbar_resampler_checker.sv
// Scoreboard for the halfband allpass resampler: watches the config, input and
// output channels, predicts every result and compares it. Depends on hbar_pkg.
`timescale 1ns / 100ps

module hbar_resampler_checker
  import hbar_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  input  wire logic                   cfg_ready_i,
  input  wire logic                   cfg_data_i,
  input  wire logic                   in_valid_i,
  input  wire logic                   in_ready_i,
  input  wire logic [TDATA_IN_W-1:0]  in_data_i,
  input  wire logic                   out_valid_i,
  input  wire logic                   out_ready_i,
  input  wire logic [TDATA_OUT_W-1:0] out_data_i,
  input  wire logic                   out_last_i,
  output int                          mismatch_count_o,
  output int                          pending_o
);

  typedef struct packed {
    logic                           last;
    logic signed [SAMPLE_WIDTH-1:0] sample;
  } filtered_t;

  // Allpass section state per path (lower = 0, upper = 1)
  logic signed [STATE_WIDTH-1:0] sect_out     [0:1][0:NUM_SECT-1];
  logic signed [STATE_WIDTH-1:0] sect_in_prev [0:1][0:NUM_SECT-1];
  mode_e                         cur_mode;
  filtered_t                     filtered_q[$];

  function automatic longint clamp(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Q0.18 section coefficients
  function automatic longint section_coef(path_e p, int k);
    longint c;
    c = 0;
    case (k)
      0: c = (p == PATH_UPPER) ? 38634  : 10263;
      1: c = (p == PATH_UPPER) ? 126476 : 79337;
      2: c = (p == PATH_UPPER) ? 231474 : 176847;
      default: c = 0;
    endcase
    return c;
  endfunction

  // Run one sample through the three sections of a path, updating its state
  function automatic longint run_path(path_e p, longint x);
    longint v;
    longint prod;
    longint rnd;
    longint y;
    int     pi;
    pi = int'(p);
    v  = x;
    for (int k = 0; k < NUM_SECT; k++) begin
      prod = (v - longint'(sect_out[pi][k])) * section_coef(p, k);
      // round half up to the sample LSB
      rnd  = (prod + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
      y    = clamp(rnd + longint'(sect_in_prev[pi][k]), STATE_WIDTH);
      sect_out[pi][k]     = STATE_WIDTH'(y);
      sect_in_prev[pi][k] = STATE_WIDTH'(v);
      v = y;
    end
    return v;
  endfunction

  task automatic predict_item(logic [TDATA_IN_W-1:0] data);
    logic signed [SAMPLE_WIDTH-1:0] first;
    logic signed [SAMPLE_WIDTH-1:0] second;
    longint                         lo;
    longint                         up;
    longint                         mean;
    filtered_t                      r;
    first  = data[SAMPLE_WIDTH-1:0];
    second = data[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    if (cur_mode == MODE_UP) begin
      lo = run_path(PATH_LOWER, longint'(first));
      up = run_path(PATH_UPPER, longint'(first));
      r.sample = SAMPLE_WIDTH'(clamp(lo, SAMPLE_WIDTH));
      r.last   = 1'b0;
      filtered_q.push_back(r);
      r.sample = SAMPLE_WIDTH'(clamp(up, SAMPLE_WIDTH));
      r.last   = 1'b1;
      filtered_q.push_back(r);
    end else begin
      up   = run_path(PATH_UPPER, longint'(first));
      lo   = run_path(PATH_LOWER, longint'(second));
      mean = (lo + up + 1) >>> 1;
      r.sample = SAMPLE_WIDTH'(clamp(mean, SAMPLE_WIDTH));
      r.last   = 1'b1;
      filtered_q.push_back(r);
    end
  endtask

  // Track config, predict on input transfers, compare on output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    filtered_t                      want;
    logic signed [SAMPLE_WIDTH-1:0] got;
    if (!rst_ni) begin
      for (int p = 0; p < 2; p++) begin
        for (int k = 0; k < NUM_SECT; k++) begin
          sect_out[p][k]     = '0;
          sect_in_prev[p][k] = '0;
        end
      end
      cur_mode = MODE_UP;
      filtered_q.delete();
      mismatch_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) cur_mode = mode_e'(cfg_data_i);
      if (in_valid_i && in_ready_i) predict_item(in_data_i);
      if (out_valid_i && out_ready_i) begin
        got = out_data_i[SAMPLE_WIDTH-1:0];
        if (filtered_q.size() == 0) begin
          $error("unexpected result transfer: sample_out %0d, last_of_run %0b",
                 got, out_last_i);
          mismatch_count_o++;
        end else begin
          want = filtered_q.pop_front();
          if (got !== want.sample) begin
            $error("sample_out mismatch: expected %0d, actual %0d", want.sample, got);
            mismatch_count_o++;
          end
          if (out_last_i !== want.last) begin
            $error("last_of_run mismatch: expected %0b, actual %0b", want.last, out_last_i);
            mismatch_count_o++;
          end
        end
      end
    end
    pending_o = filtered_q.size();
  end

endmodule

>>> tb/tb.sv
// Top of the halfband allpass resampler testbench: clock, reset, stimulus,
// receiver stalls and verdict. Depends on hbar_pkg and hbar_resampler_checker.
`timescale 1ns / 100ps

module tb;
  import hbar_pkg::*;

  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = 24'sh800000;
  localparam int PHASES         = 8;
  localparam int ITEMS_PER_PHASE = 100;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic                   cfg_data_i    = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  int mismatch_count;
  int pending_results;
  bit alt_sign;
  bit tx_gappy;

  halfband_allpass_resampler_2x DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [23:0] first_sample, [47:24] second_sample
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [23:0] sample_out
    .m_axis_tlast (m_axis_tlast)    // last_of_run
  );

  hbar_resampler_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_i      (s_axis_tready),
    .in_data_i       (s_axis_tdata),
    .out_valid_i     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_data_i      (m_axis_tdata),
    .out_last_i      (m_axis_tlast),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_results)
  );

  always #1 clk_i = ~clk_i;

  // Hard stop if the run hangs
  initial begin
    #1_500_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Mix of full-range, small, medium, extreme and sign-alternating samples
  function automatic logic [SAMPLE_WIDTH-1:0] draw_sample();
    logic [SAMPLE_WIDTH-1:0] s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: s = SAMPLE_WIDTH'($urandom);
      4:          s = SAMPLE_WIDTH'(int'($urandom_range(0, 127)) - 64);
      5:          s = SAMPLE_MAX;
      6:          s = SAMPLE_MIN;
      8:          s = SAMPLE_WIDTH'(int'($urandom_range(0, 2097151)) - 1048576);
      default: begin
        alt_sign = ~alt_sign;
        s = alt_sign ? SAMPLE_MAX : SAMPLE_MIN;
      end
    endcase
    return s;
  endfunction

  function automatic int draw_gap();
    return tx_gappy ? int'($urandom_range(0, 18)) : 0;
  endfunction

  // Present one item and hold it until the transfer
  task automatic send_item(logic [SAMPLE_WIDTH-1:0] first, logic [SAMPLE_WIDTH-1:0] second);
    s_axis_tdata  <= {second, first};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk_i);
  endtask

  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  // Hold off until every predicted result has been transferred
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_results != 0 || !s_axis_tready) @(negedge clk_i);
  endtask

  task automatic write_mode(mode_e m);
    wait_drained();
    cfg_data_i  <= m;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_paced(logic [SAMPLE_WIDTH-1:0] first, logic [SAMPLE_WIDTH-1:0] second);
    send_item(first, second);
    pause_sender(draw_gap());
  endtask

  // Receiver: random stalls before each result, in stretches with and without stalls
  initial begin
    int stall;
    int run_left;
    bit stally;
    run_left = 0;
    stally   = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (run_left == 0) begin
        stally   = ($urandom_range(0, 2) != 0);
        run_left = $urandom_range(10, 60);
      end
      run_left--;
      stall = stally ? int'($urandom_range(0, 18)) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      @(negedge clk_i);
    end
  end

  // Stimulus
  initial begin
    mode_e m;
    alt_sign = 1'b0;
    tx_gappy = 1'b1;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Upsample: extremes, steps, Nyquist-rate swings; second sample ignored
    write_mode(MODE_UP);
    send_paced('0, SAMPLE_WIDTH'($urandom));
    send_paced(SAMPLE_MAX, SAMPLE_MIN);
    send_paced(SAMPLE_MIN, SAMPLE_MAX);
    send_paced(SAMPLE_MAX, SAMPLE_WIDTH'($urandom));
    send_paced(SAMPLE_MIN, SAMPLE_WIDTH'($urandom));
    for (int i = 0; i < 4; i++) send_item(SAMPLE_MAX, SAMPLE_WIDTH'($urandom));
    send_paced(SAMPLE_WIDTH'(1), '1);
    send_paced(SAMPLE_WIDTH'(-1), '0);

    // Downsample: equal and opposite extremes, odd sums for the mean rounding
    write_mode(MODE_DOWN);
    send_paced(SAMPLE_MAX, SAMPLE_MAX);
    send_paced(SAMPLE_MAX, SAMPLE_MAX);
    send_paced(SAMPLE_MIN, SAMPLE_MIN);
    send_paced(SAMPLE_MIN, SAMPLE_MIN);
    send_paced(SAMPLE_MAX, SAMPLE_MIN);
    send_paced(SAMPLE_MIN, SAMPLE_MAX);
    send_paced(SAMPLE_WIDTH'(1), '0);
    send_paced('0, SAMPLE_WIDTH'(-1));
    send_paced(SAMPLE_WIDTH'(-1), '0);
    send_paced('0, '0);

    // Random phases, alternating the mode, with and without sender gaps
    for (int ph = 0; ph < PHASES; ph++) begin
      m = (ph % 2 == 0) ? MODE_UP : MODE_DOWN;
      write_mode(m);
      tx_gappy = ($urandom_range(0, 2) != 0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_item(draw_sample(), draw_sample());
        if ($urandom_range(0, 49) == 0) wait_drained();
        else pause_sender(draw_gap());
      end
    end

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
